// ===== design/first_fit_heap_allocator_defines.svh =====
// Assertion macros for the first-fit heap allocator.
// Used by the top level; expects clk and rst_n in scope.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FFHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ffha_pkg.sv =====
// Shared codes and field widths for the first-fit heap allocator.
// No dependencies.
package ffha_pkg;
  localparam int OFFSET_W = 16;
  localparam int REQ_W    = 16;
  localparam int STATUS_W = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOMEM  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BEYOND = 2'd3;
endpackage

// ===== design/ffha_hdr_ram.sv =====
// Chunk header memory: one write port, one read port, registered read data.
// Entry 0 carries a reset value until first written. No package use.
module ffha_hdr_ram #(
  parameter int          DEPTH  = 65536,
  parameter int          AW     = 16,
  parameter int          DW     = 18,
  parameter logic [DW-1:0] RESET0 = '0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_r;
  logic          rd_zero_r;
  logic          w0_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r      <= mem[raddr];
    rd_zero_r <= (raddr == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w0_r <= 1'b0;
    end else if (we && waddr == '0) begin
      w0_r <= 1'b1;
    end
  end

  assign rdata = (rd_zero_r && !w0_r) ? RESET0 : rd_r;
endmodule

// ===== design/first_fit_heap_allocator.sv =====
// First-fit heap allocator with inline chunk headers.
// Depends on ffha_pkg, ffha_hdr_ram and first_fit_heap_allocator_defines.svh.
//
// Usage: present a request on in_operation / in_request_bytes /
// in_payload_offset_in and raise start; it is taken at a clock edge where
// busy is low. An allocate walks the chunk headers from offset 0, each
// header visit issuing the read, then evaluating the registered memory
// data; heap growth adds one more header visit. A split writes the tail
// header first and the shrunken used header in a further step.
// A free reads its own header and each following header up to the used one
// or the heap top that ends the merge, and writes the merged header in its
// last evaluate step.
// A free rejected on its offset answers in the cycle after acceptance.
// The header memory's single read port sets the walk speed; one request is
// in flight at a time. The result appears on out_payload_offset_out /
// out_status for exactly one cycle with out_valid high; the receiver cannot
// stall it, and busy is already low in that cycle so a new request can be
// taken. Reset (synchronous, rst_n low) empties the heap to one free page at
// offset 0 and sets the heap top to one page; no memory clearing pass.
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES      = 65536,
  parameter int PAGE_BYTES      = 4096,
  parameter int MIN_CHUNK_BYTES = 16,
  parameter int HEADER_BYTES    = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_operation,
  input  logic [ffha_pkg::REQ_W-1:0]     in_request_bytes,
  input  logic [ffha_pkg::OFFSET_W-1:0]  in_payload_offset_in,
  output logic                           out_valid,
  output logic [ffha_pkg::OFFSET_W-1:0]  out_payload_offset_out,
  output logic [ffha_pkg::STATUS_W-1:0]  out_status
);
  import ffha_pkg::*;
`include "first_fit_heap_allocator_defines.svh"

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int SW = AW + 1;
  localparam int DW = SW + 1;
  localparam int CW = (AW + 2 > 18) ? AW + 2 : 18;

  localparam logic [CW-1:0] HEAP_X = CW'(HEAP_BYTES);
  localparam logic [CW-1:0] MIN_X  = CW'(MIN_CHUNK_BYTES);
  localparam logic [CW-1:0] HDR_X  = CW'(HEADER_BYTES);
  localparam logic [DW-1:0] RESET0 = {SW'(PAGE_BYTES), 1'b0};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ARD  = 3'd1;
  localparam logic [2:0] S_AEV  = 3'd2;
  localparam logic [2:0] S_ASPL = 3'd3;
  localparam logic [2:0] S_FRD  = 3'd4;
  localparam logic [2:0] S_FEV  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [SW-1:0]       top_r, top_nxt;
  logic [AW-1:0]       off_r, off_nxt;
  logic [AW-1:0]       c_r, c_nxt;
  logic [AW-1:0]       o_r, o_nxt;
  logic [CW-1:0]       acc_r, acc_nxt;
  logic                first_r, first_nxt;
  logic [CW-1:0]       real_r, real_nxt;
  logic [CW-1:0]       grow_r, grow_nxt;
  logic                ov_r, ov_nxt;
  logic [OFFSET_W-1:0] opay_r, opay_nxt;
  logic [STATUS_W-1:0] ost_r, ost_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  logic [CW-1:0] size_x, top_x, next_x, rest_x, real_in, c_in, acc_new, o_new;
  logic          used;

  ffha_hdr_ram #(
    .DEPTH (HEAP_BYTES),
    .AW    (AW),
    .DW    (DW),
    .RESET0(RESET0)
  ) u_ram (
    .clk  (clk),
    .rst_n(rst_n),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_comb begin
    size_x  = CW'(mem_rdata[DW-1:1]);
    used    = mem_rdata[0];
    top_x   = CW'(top_r);
    next_x  = CW'(off_r) + size_x;
    rest_x  = CW'(off_r) + real_r;
    real_in = HDR_X + CW'(in_request_bytes);
    if (real_in < MIN_X) begin
      real_in = MIN_X;
    end
    c_in    = CW'(in_payload_offset_in) - HDR_X;
    acc_new = first_r ? size_x : acc_r + size_x;
    o_new   = CW'(c_r) + acc_new;

    state_nxt = state_r;
    top_nxt   = top_r;
    off_nxt   = off_r;
    c_nxt     = c_r;
    o_nxt     = o_r;
    acc_nxt   = acc_r;
    first_nxt = first_r;
    real_nxt  = real_r;
    grow_nxt  = grow_r;
    ov_nxt    = 1'b0;
    opay_nxt  = opay_r;
    ost_nxt   = ost_r;
    mem_we    = 1'b0;
    mem_waddr = off_r;
    mem_wdata = '0;
    mem_raddr = off_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_operation == OP_ALLOC) begin
            real_nxt  = real_in;
            grow_nxt  = CW'((real_in / PAGE_BYTES + 1) * PAGE_BYTES);
            off_nxt   = '0;
            state_nxt = S_ARD;
          end else if (CW'(in_payload_offset_in) < HDR_X || c_in >= top_x
                       || c_in >= HEAP_X) begin
            ov_nxt   = 1'b1;
            opay_nxt = '0;
            ost_nxt  = ST_BEYOND;
          end else begin
            c_nxt     = c_in[AW-1:0];
            first_nxt = 1'b1;
            state_nxt = S_FRD;
          end
        end
      end
      S_ARD: begin
        mem_raddr = off_r;
        state_nxt = S_AEV;
      end
      S_AEV: begin
        state_nxt = S_IDLE;
        ov_nxt    = 1'b1;
        opay_nxt  = '0;
        if (size_x == '0) begin
          ost_nxt = ST_ZERO;
        end else if (!used && size_x >= real_r) begin
          if (size_x - real_r >= MIN_X) begin
            if (rest_x >= HEAP_X) begin
              ost_nxt = ST_BEYOND;
            end else begin
              // tail of the split chunk first, then shrink this one
              mem_we    = 1'b1;
              mem_waddr = rest_x[AW-1:0];
              mem_wdata = {SW'(size_x - real_r), 1'b0};
              ov_nxt    = 1'b0;
              state_nxt = S_ASPL;
            end
          end else begin
            mem_we    = 1'b1;
            mem_waddr = off_r;
            mem_wdata = {SW'(size_x), 1'b1};
            ost_nxt   = ST_OK;
            opay_nxt  = OFFSET_W'(CW'(off_r) + HDR_X);
          end
        end else if (next_x == top_x) begin
          if (grow_r > HEAP_X - top_x) begin
            ost_nxt = ST_NOMEM;
          end else if (top_x >= HEAP_X) begin
            ost_nxt = ST_BEYOND;
          end else begin
            // growth stays even if a later step fails
            mem_we    = 1'b1;
            mem_waddr = top_r[AW-1:0];
            mem_wdata = {SW'(grow_r), 1'b0};
            top_nxt   = SW'(top_x + grow_r);
            off_nxt   = top_r[AW-1:0];
            ov_nxt    = 1'b0;
            state_nxt = S_ARD;
          end
        end else if (next_x > top_x) begin
          ost_nxt = ST_BEYOND;
        end else begin
          off_nxt   = next_x[AW-1:0];
          ov_nxt    = 1'b0;
          state_nxt = S_ARD;
        end
      end
      S_ASPL: begin
        mem_we    = 1'b1;
        mem_waddr = off_r;
        mem_wdata = {SW'(real_r), 1'b1};
        ov_nxt    = 1'b1;
        ost_nxt   = ST_OK;
        opay_nxt  = OFFSET_W'(CW'(off_r) + HDR_X);
        state_nxt = S_IDLE;
      end
      S_FRD: begin
        mem_raddr = first_r ? c_r : o_r;
        state_nxt = S_FEV;
      end
      S_FEV: begin
        first_nxt = 1'b0;
        opay_nxt  = '0;
        if (!first_r && used) begin
          mem_we    = 1'b1;
          mem_waddr = c_r;
          mem_wdata = {SW'(acc_r), 1'b0};
          ov_nxt    = 1'b1;
          ost_nxt   = ST_OK;
          state_nxt = S_IDLE;
        end else if (size_x == '0) begin
          ov_nxt    = 1'b1;
          ost_nxt   = ST_ZERO;
          state_nxt = S_IDLE;
        end else begin
          acc_nxt = acc_new;
          if (o_new < top_x && o_new < HEAP_X) begin
            o_nxt     = o_new[AW-1:0];
            state_nxt = S_FRD;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = c_r;
            mem_wdata = {SW'(acc_new), 1'b0};
            ov_nxt    = 1'b1;
            ost_nxt   = ST_OK;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      top_r   <= SW'(PAGE_BYTES);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
      ov_r    <= ov_nxt;
    end
    off_r   <= off_nxt;
    c_r     <= c_nxt;
    o_r     <= o_nxt;
    acc_r   <= acc_nxt;
    first_r <= first_nxt;
    real_r  <= real_nxt;
    grow_r  <= grow_nxt;
    opay_r  <= opay_nxt;
    ost_r   <= ost_nxt;
  end

  assign busy                   = (state_r != S_IDLE);
  assign out_valid              = ov_r;
  assign out_payload_offset_out = opay_r;
  assign out_status             = ost_r;

  `FFHA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid, "request neither in progress nor answered")
  `FFHA_ASSERT_NOW(a_strobe_idle, out_valid, !busy, "result strobe while busy")
  `FFHA_ASSERT_NOW(a_err_zero_pay, out_valid && out_status != ST_OK, out_payload_offset_out == '0, "error result with nonzero offset")
  `FFHA_ASSERT_NOW(a_top_bound, 1'b1, CW'(top_r) <= HEAP_X, "heap top beyond heap size")
endmodule

// ===== tb/tb_first_fit_heap_allocator.sv =====
// Self-checking testbench for first_fit_heap_allocator: a directed table, then random
// allocate/free traffic, checked against a predictor of the heap. Depends on ffha_pkg and first_fit_heap_allocator.
`timescale 1ns / 100ps
module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam int HEAP_BYTES = 65536;
  localparam int PAGE_BYTES = 4096;
  localparam int MIN_CHUNK  = 16;
  localparam int HDR_BYTES  = 8;
  localparam int RANDOM_ITEMS = 450;
  localparam int STALL_LIMIT  = 60000;

  typedef struct packed {
    logic [OFFSET_W-1:0] payload;
    logic [STATUS_W-1:0] status;
  } alloc_result_t;

  typedef struct {
    logic                op;
    logic [REQ_W-1:0]    req;
    logic [OFFSET_W-1:0] pay;
    bit                  typed;
    alloc_result_t       res;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_operation = OP_ALLOC;
  logic [REQ_W-1:0]    in_request_bytes = '0;
  logic [OFFSET_W-1:0] in_payload_offset_in = '0;
  logic                out_valid;
  logic [OFFSET_W-1:0] out_payload_offset_out;
  logic [STATUS_W-1:0] out_status;

  first_fit_heap_allocator DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_request_bytes(in_request_bytes),
    .in_payload_offset_in(in_payload_offset_in), .out_valid(out_valid),
    .out_payload_offset_out(out_payload_offset_out), .out_status(out_status)
  );

  always #2 clk = ~clk;

  // heap image: size and used bit per written header offset
  int unsigned   chunk_size[int unsigned];
  bit            chunk_used[int unsigned];
  int unsigned   written_offs[$];
  int unsigned   heap_top;
  alloc_result_t expected_results[$];
  int            mismatches = 0;
  int            idle_cycles = 0;

  function automatic void put_header(int unsigned off, int unsigned size, bit used);
    if (!chunk_size.exists(off)) written_offs.push_back(off);
    chunk_size[off] = size;
    chunk_used[off] = used;
  endfunction

  function automatic logic [STATUS_W-1:0] heap_alloc(int unsigned req, output int unsigned pay);
    int unsigned need, off, size, nxt, grow;
    need = HDR_BYTES + req;
    off = 0;
    pay = 0;
    if (need < MIN_CHUNK) need = MIN_CHUNK;
    forever begin
      size = chunk_size[off];
      if (size == 0) return ST_ZERO;
      if (!chunk_used[off] && size >= need) break;
      nxt = off + size;
      if (nxt == heap_top) begin
        grow = (need / PAGE_BYTES + 1) * PAGE_BYTES;
        if (grow > HEAP_BYTES - heap_top) return ST_NOMEM;
        if (heap_top >= HEAP_BYTES) return ST_BEYOND;
        put_header(heap_top, grow, 1'b0);
        heap_top += grow;
      end else if (nxt > heap_top) begin
        return ST_BEYOND;
      end
      off = nxt;
    end
    if (chunk_size[off] - need >= MIN_CHUNK) begin
      if (off + need >= HEAP_BYTES) return ST_BEYOND;
      put_header(off + need, chunk_size[off] - need, 1'b0);
      chunk_size[off] = need;
    end
    chunk_used[off] = 1'b1;
    pay = off + HDR_BYTES;
    return ST_OK;
  endfunction

  // dry = 1: only report whether every header read was written before
  function automatic logic [STATUS_W-1:0] heap_free(int unsigned pay, bit dry, output bit safe);
    int unsigned c, acc, o;
    safe = 1'b1;
    if (pay < HDR_BYTES) return ST_BEYOND;
    c = pay - HDR_BYTES;
    if (c >= heap_top || c >= HEAP_BYTES) return ST_BEYOND;
    if (!chunk_size.exists(c)) begin
      safe = 1'b0;
      return ST_ZERO;
    end
    acc = chunk_size[c];
    if (acc == 0) return ST_ZERO;
    o = c + acc;
    while (o < heap_top && o < HEAP_BYTES) begin
      if (!chunk_size.exists(o)) begin
        safe = 1'b0;
        return ST_ZERO;
      end
      if (chunk_used[o]) break;
      if (chunk_size[o] == 0) return ST_ZERO;
      acc += chunk_size[o];
      o = c + acc;
    end
    if (!dry) begin
      chunk_used[c] = 1'b0;
      chunk_size[c] = acc;
    end
    return ST_OK;
  endfunction

  function automatic alloc_result_t predict_request(logic op, int unsigned req, int unsigned pin);
    alloc_result_t r;
    int unsigned pay;
    bit safe;
    if (op == OP_ALLOC) r.status = heap_alloc(req, pay);
    else begin
      r.status = heap_free(pin, 1'b0, safe);
      pay = 0;
    end
    r.payload = (r.status == ST_OK) ? pay[OFFSET_W-1:0] : '0;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // request is driven at a posedge and taken at the first edge with busy low
  task automatic issue(logic op, int unsigned req, int unsigned pin, bit typed,
                       alloc_result_t want);
    alloc_result_t p;
    in_operation <= op;
    in_request_bytes <= req[REQ_W-1:0];
    in_payload_offset_in <= pin[OFFSET_W-1:0];
    start <= 1'b1;
    do @(negedge clk); while (busy);
    @(posedge clk);
    p = predict_request(op, req, pin);
    expected_results.push_back(typed ? want : p);
    idle_cycles = 0;
  endtask

  function automatic int unsigned pick_free_offset();
    int unsigned chain[$];
    int unsigned off, cand;
    bit safe;
    off = 0;
    while (off < heap_top && chunk_size.exists(off) && chunk_size[off] != 0) begin
      chain.push_back(off);
      off += chunk_size[off];
    end
    case ($urandom_range(0, 19))
      0, 1: return $urandom_range(0, HDR_BYTES - 1);
      2, 3: return (heap_top + HDR_BYTES <= 65535) ?
                   $urandom_range(heap_top + HDR_BYTES, 65535) : $urandom_range(0, 7);
      4, 5: begin
        cand = written_offs[$urandom_range(0, written_offs.size() - 1)];
        void'(heap_free(cand + HDR_BYTES, 1'b1, safe));
        if (safe && cand + HDR_BYTES <= 65535) return cand + HDR_BYTES;
      end
      default: ;
    endcase
    return chain[$urandom_range(0, chain.size() - 1)] + HDR_BYTES;
  endfunction

  function automatic int unsigned pick_request_bytes();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 70) return $urandom_range(0, 120);
    if (k < 90) return $urandom_range(121, 3000);
    if (k < 97) return $urandom_range(3001, 20000);
    return $urandom_range(20001, 65535);
  endfunction

  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_valid) begin
      idle_cycles = 0;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(out_status), 0);
      end else begin
        e = expected_results.pop_front();
        if (out_status !== e.status)
          report_mismatch("status", 32'(out_status), 32'(e.status));
        if (out_payload_offset_out !== e.payload)
          report_mismatch("payload offset", 32'(out_payload_offset_out), 32'(e.payload));
      end
    end
  end

  always @(posedge clk) begin
    idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  stim_row_t directed[$];

  function automatic stim_row_t row(logic op, int unsigned req, int unsigned pin, bit typed,
                                    int unsigned pay, logic [STATUS_W-1:0] st);
    stim_row_t r;
    r.op = op;
    r.req = req[REQ_W-1:0];
    r.pay = pin[OFFSET_W-1:0];
    r.typed = typed;
    r.res.payload = pay[OFFSET_W-1:0];
    r.res.status = st;
    return r;
  endfunction

  initial begin
    int unsigned n, phase, gap;
    bit sender_idles;
    heap_top = PAGE_BYTES;
    put_header(0, PAGE_BYTES, 1'b0);

    directed.push_back(row(OP_ALLOC, 0, 0, 1, 8, ST_OK));
    directed.push_back(row(OP_ALLOC, 8, 0, 1, 24, ST_OK));
    directed.push_back(row(OP_FREE, 0, 24, 1, 0, ST_OK));
    directed.push_back(row(OP_FREE, 0, 0, 1, 0, ST_BEYOND));
    directed.push_back(row(OP_FREE, 0, 7, 1, 0, ST_BEYOND));
    directed.push_back(row(OP_FREE, 0, 65535, 1, 0, ST_BEYOND));
    directed.push_back(row(OP_FREE, 0, PAGE_BYTES + HDR_BYTES, 1, 0, ST_BEYOND));
    directed.push_back(row(OP_ALLOC, 65535, 65535, 1, 0, ST_NOMEM));
    directed.push_back(row(OP_ALLOC, 7, 0, 0, 0, ST_OK));
    directed.push_back(row(OP_ALLOC, 4000, 0, 0, 0, ST_OK));
    directed.push_back(row(OP_ALLOC, 10000, 0, 0, 0, ST_OK));
    directed.push_back(row(OP_FREE, 0, 24, 0, 0, ST_OK));
    directed.push_back(row(OP_FREE, 0, 24, 0, 0, ST_OK));
    directed.push_back(row(OP_ALLOC, 1, 0, 0, 0, ST_OK));
    directed.push_back(row(OP_FREE, 0, 8, 0, 0, ST_OK));
    directed.push_back(row(OP_ALLOC, 40000, 0, 0, 0, ST_OK));
    directed.push_back(row(OP_ALLOC, 20000, 0, 0, 0, ST_NOMEM));
    directed.push_back(row(OP_FREE, 0, 8, 0, 0, ST_OK));
    directed.push_back(row(OP_ALLOC, 16'hAAAA, 16'h5555, 0, 0, ST_OK));
    directed.push_back(row(OP_ALLOC, 16'h5555, 16'hAAAA, 0, 0, ST_OK));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      issue(directed[i].op, directed[i].req, directed[i].pay, directed[i].typed,
            directed[i].res);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      phase = n / (RANDOM_ITEMS / 4);
      // phases: no idling, sender idle 60%, no idling (receiver cannot stall), 26%
      sender_idles = (phase == 1) ? ($urandom_range(0, 99) < 60) :
                     (phase == 3) ? ($urandom_range(0, 99) < 26) : 1'b0;
      if (n == RANDOM_ITEMS / 2) begin
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
      end else if (sender_idles) begin
        start <= 1'b0;
        gap = $urandom_range(1, 6);
        repeat (gap) @(posedge clk);
      end
      if ($urandom_range(0, 99) < 55)
        issue(OP_ALLOC, pick_request_bytes(), $urandom_range(0, 65535), 0, '0);
      else
        issue(OP_FREE, $urandom_range(0, 65535), pick_free_offset(), 0, '0);
    end
    start <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
